// ===== rtl/rpq_pkg.sv =====
// rpq_pkg: shared constants, codes and controller/datapath interface types
// for the ring priority queue. No dependencies.
`timescale 1ns / 1ps

package rpq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int PRIO_W        = 4;
    localparam int DATA_W        = 32;
    localparam int STS_W         = 2;
    localparam int ENT_W         = PRIO_W + DATA_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic insert;
        logic remove_empty;
        logic remove_start;
        logic scan;
        logic shift_rd;
        logic shift_wr;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_done;
        logic shift_done;
    } sts_t;

endpackage

// ===== rtl/rpq_ctrl.sv =====
// rpq_ctrl: sequencer for insert, scan, shift and result hand-off.
// Depends on rpq_pkg (cmd_t, sts_t, operation codes).
`timescale 1ns / 1ps

module rpq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          op,
    input  logic          out_free,
    input  rpq_pkg::sts_t sts,
    output rpq_pkg::cmd_t cmd,
    output logic          in_ready
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCAN     = 5'b00010,
        ST_SHIFT_RD = 5'b00100,
        ST_SHIFT_WR = 5'b01000,
        ST_RESP     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op == rpq_pkg::OP_INSERT) begin
                        cmd.insert = 1'b1;
                        state_next = ST_RESP;
                    end else if (sts.empty) begin
                        cmd.remove_empty = 1'b1;
                        state_next       = ST_RESP;
                    end else begin
                        cmd.remove_start = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (sts.shift_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rpq_dpath.sv =====
// rpq_dpath: entry store, ring indices, fill count, priority scan and gap shift.
// Depends on rpq_pkg (cmd_t, sts_t, widths, status codes).
`timescale 1ns / 1ps

module rpq_dpath #(
    parameter int DEPTH = rpq_pkg::DEFAULT_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rpq_pkg::cmd_t               cmd,
    output rpq_pkg::sts_t               sts,
    input  logic [rpq_pkg::PRIO_W-1:0]  in_prio,
    input  logic [rpq_pkg::DATA_W-1:0]  in_payload,
    output logic [rpq_pkg::STS_W-1:0]   res_status,
    output logic [rpq_pkg::PRIO_W-1:0]  res_prio,
    output logic [rpq_pkg::DATA_W-1:0]  res_payload
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_I = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_I) begin
            s = s - DEPTH_I;
        end
        return s[IDX_W-1:0];
    endfunction

    logic [rpq_pkg::ENT_W-1:0] mem [DEPTH];
    logic [rpq_pkg::ENT_W-1:0] rdata_reg;

    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          rd_off_reg, rd_off_next;
    logic                      rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]          roff_reg, roff_next;
    logic [IDX_W-1:0]          best_off_reg, best_off_next;
    logic [rpq_pkg::PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [rpq_pkg::DATA_W-1:0] best_payload_reg, best_payload_next;
    logic [rpq_pkg::STS_W-1:0]  status_reg, status_next;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [rpq_pkg::ENT_W-1:0] mem_wdata;
    logic                      mem_rd;
    logic [IDX_W-1:0]          mem_raddr;

    logic                       full;
    logic [rpq_pkg::PRIO_W-1:0] rd_prio;

    assign full    = (count_reg == DEPTH_C);
    assign rd_prio = rdata_reg[rpq_pkg::DATA_W +: rpq_pkg::PRIO_W];

    assign sts.empty      = (count_reg == '0);
    assign sts.scan_done  = (rd_off_reg == count_reg) && !rvalid_reg;
    assign sts.shift_done = (best_off_reg == '0);

    assign res_status  = status_reg;
    assign res_prio    = best_prio_reg;
    assign res_payload = best_payload_reg;

    always_comb begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        rd_off_next       = rd_off_reg;
        rvalid_next       = 1'b0;
        roff_next         = roff_reg;
        best_off_next     = best_off_reg;
        best_prio_next    = best_prio_reg;
        best_payload_next = best_payload_reg;
        status_next       = status_reg;
        mem_we            = 1'b0;
        mem_waddr         = tail_reg;
        mem_wdata         = rdata_reg;
        mem_rd            = 1'b0;
        mem_raddr         = head_reg;

        if (cmd.insert) begin
            best_prio_next    = '0;
            best_payload_next = '0;
            if (full) begin
                status_next = rpq_pkg::STS_FULL;
            end else begin
                status_next = rpq_pkg::STS_OK;
                mem_we      = 1'b1;
                mem_waddr   = tail_reg;
                mem_wdata   = {in_prio, in_payload};
                tail_next   = ring_add(tail_reg, IDX_W'(1));
                count_next  = count_reg + CNT_W'(1);
            end
        end

        if (cmd.remove_empty) begin
            status_next       = rpq_pkg::STS_EMPTY;
            best_prio_next    = '0;
            best_payload_next = '0;
        end

        if (cmd.remove_start) begin
            status_next   = rpq_pkg::STS_OK;
            rd_off_next   = '0;
            best_off_next = '0;
        end

        if (cmd.scan) begin
            if (rd_off_reg < count_reg) begin
                mem_rd      = 1'b1;
                mem_raddr   = ring_add(head_reg, rd_off_reg[IDX_W-1:0]);
                rvalid_next = 1'b1;
                roff_next   = rd_off_reg[IDX_W-1:0];
                rd_off_next = rd_off_reg + CNT_W'(1);
            end
            if (rvalid_reg && ((roff_reg == '0) || (rd_prio < best_prio_reg))) begin
                best_prio_next    = rd_prio;
                best_payload_next = rdata_reg[rpq_pkg::DATA_W-1:0];
                best_off_next     = roff_reg;
            end
        end

        if (cmd.shift_rd) begin
            mem_rd    = 1'b1;
            mem_raddr = ring_add(head_reg, best_off_reg - IDX_W'(1));
        end

        if (cmd.shift_wr) begin
            mem_we        = 1'b1;
            mem_waddr     = ring_add(head_reg, best_off_reg);
            mem_wdata     = rdata_reg;
            best_off_next = best_off_reg - IDX_W'(1);
        end

        if (cmd.finish) begin
            head_next  = ring_add(head_reg, IDX_W'(1));
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            rd_off_reg <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rd_off_reg <= rd_off_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        roff_reg         <= roff_next;
        best_off_reg     <= best_off_next;
        best_prio_reg    <= best_prio_next;
        best_payload_reg <= best_payload_next;
        status_reg       <= status_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count beyond depth");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        full ? (tail_reg == head_reg)
             : (tail_reg == ring_add(head_reg, count_reg[IDX_W-1:0])))
        else $error("tail does not match head plus count");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add an entry");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not drop an entry");

endmodule

// ===== rtl/ring_priority_queue.sv =====
// ring_priority_queue: top level, joins controller, datapath and result register.
// Depends on rpq_pkg, rpq_ctrl, rpq_dpath.
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries in a single ring memory. One beat in
// gives one beat out. An insert (or a full/empty report) goes from acceptance
// to the result state and then to the output register. A remove on n held
// entries whose winner sits k places behind the head makes one memory read
// per entry for the priority scan, then a read and a write for each of the k
// entries ahead of the winner for the gap shift, with every read through the
// memory's single read port. The input takes a new beat once the previous result has moved to the output register.

module ring_priority_queue #(
    parameter int DEPTH = rpq_pkg::DEFAULT_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic        [rpq_pkg::PRIO_W-1:0] s_priority_req,
    input  logic signed [rpq_pkg::DATA_W-1:0] s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [rpq_pkg::STS_W-1:0]  m_status,
    output logic        [rpq_pkg::PRIO_W-1:0] m_out_priority,
    output logic signed [rpq_pkg::DATA_W-1:0] m_out_payload
);

    rpq_pkg::cmd_t cmd;
    rpq_pkg::sts_t sts;

    logic                       accept;
    logic                       out_free;
    logic [rpq_pkg::STS_W-1:0]  res_status;
    logic [rpq_pkg::PRIO_W-1:0] res_prio;
    logic [rpq_pkg::DATA_W-1:0] res_payload;

    logic                       m_valid_reg, m_valid_next;
    logic [rpq_pkg::STS_W-1:0]  m_status_reg;
    logic [rpq_pkg::PRIO_W-1:0] m_prio_reg;
    logic [rpq_pkg::DATA_W-1:0] m_payload_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    rpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (s_operation),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    rpq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_prio     (s_priority_req),
        .in_payload  (s_payload),
        .res_status  (res_status),
        .res_prio    (res_prio),
        .res_payload (res_payload)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg  <= res_status;
            m_prio_reg    <= res_prio;
            m_payload_reg <= res_payload;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_priority = m_prio_reg;
    assign m_out_payload  = $signed(m_payload_reg);

endmodule

// ===== tb/rpq_checker.sv =====
// rpq_checker: watches both channels of ring_priority_queue, keeps its own
// copy of the queue contents, predicts every result beat and compares it.
// Depends on rpq_pkg.
`timescale 1ns / 1ps

module rpq_checker
    import rpq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_operation,
    input  logic        [PRIO_W-1:0] s_priority_req,
    input  logic signed [DATA_W-1:0] s_payload,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic        [STS_W-1:0]  m_status,
    input  logic        [PRIO_W-1:0] m_out_priority,
    input  logic signed [DATA_W-1:0] m_out_payload,
    output int unsigned              mismatches,
    output int unsigned              pending
);

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } outcome_t;

    logic [PRIO_W-1:0] slot_prio [DEPTH];
    logic [DATA_W-1:0] slot_data [DEPTH];
    int                head_pos;
    int                tail_pos;
    int                held;
    outcome_t          awaited_outcomes [$];
    int unsigned       results_seen;

    initial begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch: result beat %0d, %s got %0h want %0h at %0t",
                 results_seen, field, got, want, $realtime);
        mismatches++;
    endtask

    // Smallest priority wins, oldest among equals; the older entries slide
    // one slot toward the tail, then the head moves on.
    function automatic outcome_t serve_beat(input logic op, input logic [PRIO_W-1:0] prio,
                                            input logic [DATA_W-1:0] data);
        outcome_t          r = '0;
        int                best_off;
        logic [PRIO_W-1:0] best_prio;
        if (op == OP_INSERT) begin
            if (held >= DEPTH) begin
                r.status = STS_FULL;
            end else begin
                slot_prio[tail_pos] = prio;
                slot_data[tail_pos] = data;
                tail_pos = (tail_pos + 1) % DEPTH;
                held++;
                r.status = STS_OK;
            end
        end else if (held == 0) begin
            r.status = STS_EMPTY;
        end else begin
            best_off  = 0;
            best_prio = slot_prio[head_pos];
            for (int k = 1; k < held; k++) begin
                if (slot_prio[(head_pos + k) % DEPTH] < best_prio) begin
                    best_prio = slot_prio[(head_pos + k) % DEPTH];
                    best_off  = k;
                end
            end
            r.status = STS_OK;
            r.prio   = slot_prio[(head_pos + best_off) % DEPTH];
            r.data   = slot_data[(head_pos + best_off) % DEPTH];
            for (int k = best_off; k > 0; k--) begin
                slot_prio[(head_pos + k) % DEPTH] = slot_prio[(head_pos + k - 1) % DEPTH];
                slot_data[(head_pos + k) % DEPTH] = slot_data[(head_pos + k - 1) % DEPTH];
            end
            head_pos = (head_pos + 1) % DEPTH;
            held--;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        outcome_t want;
        if (!aresetn) begin
            head_pos = 0;
            tail_pos = 0;
            held     = 0;
            awaited_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected beat, status", m_status, '0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_out_priority !== want.prio)
                        report_mismatch("priority", m_out_priority, want.prio);
                    if (m_out_payload !== want.data)
                        report_mismatch("payload", m_out_payload, want.data);
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                awaited_outcomes.push_back(serve_beat(s_operation, s_priority_req, s_payload));
        end
        pending = awaited_outcomes.size();
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus, handshake pacing and verdict for ring_priority_queue.
// Depends on rpq_pkg, ring_priority_queue and rpq_checker.
`timescale 1ns / 1ps

module tb;
    import rpq_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_operation = OP_INSERT;
    logic        [PRIO_W-1:0] s_priority_req = '0;
    logic signed [DATA_W-1:0] s_payload = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic        [STS_W-1:0]  m_status;
    logic        [PRIO_W-1:0] m_out_priority;
    logic signed [DATA_W-1:0] m_out_payload;

    int unsigned mismatches;
    int unsigned pending;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold     = 1'b0;
    int          quiet_cycles = 0;

    always #4 aclk = ~aclk;

    ring_priority_queue #(.DEPTH(DEPTH)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_priority_req (s_priority_req),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_priority (m_out_priority),
        .m_out_payload  (m_out_payload)
    );

    rpq_checker #(.DEPTH(DEPTH)) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_priority_req (s_priority_req),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_priority (m_out_priority),
        .m_out_payload  (m_out_payload),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic op, input logic [PRIO_W-1:0] prio,
                             input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_priority_req <= prio;
        s_payload      <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(3))
            0:       return $urandom_range(15);
            1:       return $urandom_range(3);
            2:       return $urandom_range(15, 12);
            default: return $urandom_range(1) ? 4'd15 : 4'd0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_payload();
        if ($urandom_range(7) != 0)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Bursts lean towards filling or draining so that full and empty both recur.
    task automatic random_traffic(input int n_beats);
        int insert_pct;
        int left;
        left = n_beats;
        while (left > 0) begin
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            repeat ($urandom_range(40, 10)) begin
                if (left > 0) begin
                    send_beat(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                              pick_priority(), pick_payload());
                    left--;
                end
            end
        end
    endtask

    task automatic set_pacing(input int tx_pct, input int rx_pct);
        s_valid <= 1'b0;
        @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(negedge aclk);
    endtask

    logic [PRIO_W-1:0] fill_prio [16] = '{7, 3, 15, 0, 3, 0, 15, 8, 1, 1, 9, 0, 12, 15, 2, 4};

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_pacing(29, 68);
        send_beat(OP_REMOVE, 4'd15, 32'hffff_ffff);
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       send_beat(OP_INSERT, fill_prio[i], 32'h8000_0000);
                1:       send_beat(OP_INSERT, fill_prio[i], 32'h7fff_ffff);
                2:       send_beat(OP_INSERT, fill_prio[i], 32'h0000_0000);
                3:       send_beat(OP_INSERT, fill_prio[i], 32'hffff_ffff);
                default: send_beat(OP_INSERT, fill_prio[i], $urandom);
            endcase
        end
        send_beat(OP_INSERT, 4'd0, 32'h1234_5678);
        repeat (5) send_beat(OP_REMOVE, $urandom_range(15), $urandom);
        random_traffic(270);

        set_pacing(68, 29);
        random_traffic(280);

        set_pacing(0, 0);
        fork
            begin
                @(posedge aclk);
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        random_traffic(280);
        s_valid <= 1'b0;

        while (pending != 0 || rx_hold) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
